// ----- hw/rtl/ird_pkg.sv -----
// Package for the radix digit converter: state encoding, field widths and
// parameter defaults. No dependencies.
package ird_pkg;

  localparam int unsigned RadixW         = 9;
  localparam int unsigned DigitW         = 8;
  localparam int unsigned MaxDigitsDflt  = 32;
  localparam int unsigned ValueBitsDflt  = 31;

  localparam logic [RadixW-1:0] RadixReset = 9'd10;
  localparam logic [RadixW-1:0] RadixMin   = 9'd2;
  localparam logic [RadixW-1:0] RadixMax   = 9'd256;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_READ,
    ST_EMIT,
    ST_ZERO
  } ird_state_e;

endpackage

// ----- hw/rtl/integer_to_radix_digits_core.sv -----
// Radix digit converter: repeated division by the configured base, digits
// stacked in a local memory and emitted most significant first.
// Depends on ird_pkg.
//
// Each accepted value is divided by the radix with a restoring divider that
// retires one quotient bit a cycle, a full VALUE_BITS-bit division per digit;
// its remainder is written to the digit stack memory. Once the quotient
// reaches zero (or MAX_DIGITS digits are stacked) the stack is read back,
// each digit through a memory read state and then an output state that
// waits out any output stall. A zero input gives one transfer with digit 0,
// last_digit_o and empty_res_o set, offered in the cycle after acceptance.
// One value is in flight at a time: in_stall_o is low only while the block
// is idle. Radix values of 0 or 1 act as 2, values above 256 act as 256;
// the radix is written through the cfg channel, which is always ready.
module integer_to_radix_digits_core
  import ird_pkg::*;
#(
  parameter int unsigned MAX_DIGITS = MaxDigitsDflt,
  parameter int unsigned VALUE_BITS = ValueBitsDflt
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // configuration
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [RadixW-1:0]     cfg_radix_i,
  // input channel
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [VALUE_BITS-1:0] value_i,
  // output channel
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [DigitW-1:0]     digit_o,
  output logic                  last_digit_o,
  output logic                  empty_res_o
);

  localparam int unsigned AddrW = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
  localparam int unsigned CntW  = $clog2(MAX_DIGITS + 1);
  localparam int unsigned BitW  = (VALUE_BITS > 1) ? $clog2(VALUE_BITS) : 1;
  localparam int unsigned RemW  = RadixW + 1;

  localparam logic [BitW-1:0] LastBit   = BitW'(VALUE_BITS - 1);
  localparam logic [CntW-1:0] CntFull   = CntW'(MAX_DIGITS);
  localparam logic [CntW-1:0] CntOne    = CntW'(1);

  ird_state_e state_q, state_d;

  logic [RadixW-1:0]     radix_q;
  logic [RadixW-1:0]     base;
  logic [VALUE_BITS-1:0] quot_q, quot_d;
  logic [RadixW-1:0]     rem_q, rem_d;
  logic [BitW-1:0]       bit_cnt_q, bit_cnt_d;
  logic [CntW-1:0]       cnt_q, cnt_d;

  logic [RemW-1:0]       rem_sh;
  logic                  rem_ge;
  logic [RadixW-1:0]     rem_next;
  logic [VALUE_BITS-1:0] quot_next;
  logic                  digit_done;
  logic [CntW-1:0]       cnt_inc;

  logic [DigitW-1:0]     stack_mem [MAX_DIGITS];
  logic                  wr_en, rd_en;
  logic [AddrW-1:0]      wr_addr, rd_addr;
  logic [DigitW-1:0]     rd_data_q;
  logic [CntW-1:0]       cnt_dec;

  logic in_xfer, out_xfer;

  assign cfg_ready_o = 1'b1;
  assign in_xfer     = in_valid_i & ~in_stall_o;
  assign out_xfer    = out_valid_o & ~out_stall_i;

  // Radix register, saturated on use
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radix_q <= RadixReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      radix_q <= cfg_radix_i;
    end
  end

  always_comb begin
    if (radix_q < RadixMin) begin
      base = RadixMin;
    end else if (radix_q > RadixMax) begin
      base = RadixMax;
    end else begin
      base = radix_q;
    end
  end

  // Restoring divider step: one quotient bit a cycle, quotient shifts in place
  assign rem_sh    = {rem_q, quot_q[VALUE_BITS-1]};
  assign rem_ge    = rem_sh >= {1'b0, base};
  assign rem_next  = rem_ge ? RadixW'(rem_sh - {1'b0, base}) : RadixW'(rem_sh);
  assign quot_next = {quot_q[VALUE_BITS-2:0], rem_ge};
  assign digit_done = (bit_cnt_q == LastBit);
  assign cnt_inc   = cnt_q + CntOne;
  assign cnt_dec   = cnt_q - CntOne;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          state_d = (value_i == '0) ? ST_ZERO : ST_DIV;
        end
      end
      ST_DIV: begin
        if (digit_done && ((quot_next == '0) || (cnt_inc == CntFull))) begin
          state_d = ST_READ;
        end
      end
      ST_READ: state_d = ST_EMIT;
      ST_EMIT: begin
        if (out_xfer) begin
          state_d = (cnt_q == CntOne) ? ST_IDLE : ST_READ;
        end
      end
      ST_ZERO: begin
        if (out_xfer) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Datapath next values
  always_comb begin
    quot_d    = quot_q;
    rem_d     = rem_q;
    bit_cnt_d = bit_cnt_q;
    cnt_d     = cnt_q;
    wr_en     = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          quot_d    = value_i;
          rem_d     = '0;
          bit_cnt_d = '0;
          cnt_d     = '0;
        end
      end
      ST_DIV: begin
        quot_d = quot_next;
        if (digit_done) begin
          wr_en     = 1'b1;
          cnt_d     = cnt_inc;
          rem_d     = '0;
          bit_cnt_d = '0;
        end else begin
          rem_d     = rem_next;
          bit_cnt_d = bit_cnt_q + BitW'(1);
        end
      end
      ST_EMIT: begin
        if (out_xfer) begin
          cnt_d = cnt_dec;
        end
      end
      default: ;
    endcase
  end

  assign wr_addr = cnt_q[AddrW-1:0];
  assign rd_en   = (state_q == ST_READ);
  assign rd_addr = cnt_dec[AddrW-1:0];

  // Outputs
  always_comb begin
    in_stall_o   = 1'b1;
    out_valid_o  = 1'b0;
    digit_o      = rd_data_q;
    last_digit_o = (cnt_q == CntOne);
    empty_res_o  = 1'b0;
    unique case (state_q)
      ST_IDLE: in_stall_o = 1'b0;
      ST_EMIT: out_valid_o = 1'b1;
      ST_ZERO: begin
        out_valid_o  = 1'b1;
        digit_o      = '0;
        last_digit_o = 1'b1;
        empty_res_o  = 1'b1;
      end
      default: ;
    endcase
  end

  // Digit stack, read data registered
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      stack_mem[wr_addr] <= rem_next[DigitW-1:0];
    end
    if (rd_en) begin
      rd_data_q <= stack_mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      bit_cnt_q <= '0;
      cnt_q     <= '0;
    end else begin
      state_q   <= state_d;
      bit_cnt_q <= bit_cnt_d;
      cnt_q     <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
  end

endmodule

// ----- hw/rtl/ird_checker.sv -----
// Port-level checks for the radix digit converter, bound to the top level.
// Depends on ird_pkg and integer_to_radix_digits_core.
module ird_checker
  import ird_pkg::*;
#(
  parameter int unsigned VALUE_BITS = ValueBitsDflt
) (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  in_valid_i,
  input logic                  in_stall_o,
  input logic [VALUE_BITS-1:0] value_i,
  input logic                  out_valid_o,
  input logic                  out_stall_i,
  input logic                  last_digit_o,
  input logic                  empty_res_o
);

  // a pending result holds until its transfer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && empty_res_o |-> last_digit_o)
    else $error("empty result not marked last");

  // one value in flight: no input transfer while digits are pending
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("input taken while output busy");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && (value_i == '0) |=> out_valid_o && empty_res_o)
    else $error("zero input did not give empty result");

endmodule

bind integer_to_radix_digits_core ird_checker #(
  .VALUE_BITS(VALUE_BITS)
) u_ird_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_stall_o   (in_stall_o),
  .value_i      (value_i),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .last_digit_o (last_digit_o),
  .empty_res_o  (empty_res_o)
);

// ----- dv/tb.sv -----
`timescale 1ns / 1ps
// Testbench for integer_to_radix_digits_core: directed table then random values over
// a range of radix settings, every digit transfer checked against a local predictor or a table row.
// Depends on ird_pkg and the core RTL.
module tb;
  import ird_pkg::*;

  localparam int unsigned ValueW     = ValueBitsDflt;
  localparam int unsigned StackDepth = MaxDigitsDflt;
  localparam int unsigned ShowMax    = 10;
  localparam longint unsigned ValueMax = (64'd1 << ValueW) - 1;

  typedef struct packed {
    logic [DigitW-1:0] digit;
    logic              last_digit;
    logic              empty_res;
  } digit_res_t;

  typedef struct packed {
    logic              set_radix;
    logic [RadixW-1:0] radix;
    logic [ValueW-1:0] value;
    logic              typed;
    logic [DigitW-1:0] exp_digit;
    logic              exp_empty;
  } dir_row_t;

  logic              clk_i       = 1'b0;
  logic              rst_ni      = 1'b0;
  logic              cfg_valid_i = 1'b0;
  logic              cfg_ready_o;
  logic [RadixW-1:0] cfg_radix_i = '0;
  logic              in_valid_i  = 1'b0;
  logic              in_stall_o;
  logic [ValueW-1:0] value_i     = '0;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  logic [DigitW-1:0] digit_o;
  logic              last_digit_o;
  logic              empty_res_o;

  digit_res_t        digits_due[$];
  logic [RadixW-1:0] radix_now = RadixReset;
  bit                calm      = 1'b0;
  int                stall_left = 0;
  int unsigned       n_values   = 0;
  int unsigned       n_digits   = 0;
  int unsigned       n_bad      = 0;
  int unsigned       n_writes   = 0;

  integer_to_radix_digits_core u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_radix_i  (cfg_radix_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .value_i      (value_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .digit_o      (digit_o),
    .last_digit_o (last_digit_o),
    .empty_res_o  (empty_res_o)
  );

  always #5 clk_i = ~clk_i;

  // radix 0/1 act as 2, anything above 256 saturates
  function automatic int unsigned eff_radix(input logic [RadixW-1:0] r);
    if (r < RadixMin) return RadixMin;
    if (r > RadixMax) return RadixMax;
    return r;
  endfunction

  function automatic void predict_digits(input logic [ValueW-1:0] v);
    logic [DigitW-1:0] stack [StackDepth];
    int unsigned       quot;
    int unsigned       base;
    int unsigned       cnt;
    digit_res_t        res;
    base = eff_radix(radix_now);
    quot = v;
    cnt  = 0;
    if (quot == 0) begin
      res = '{digit: '0, last_digit: 1'b1, empty_res: 1'b1};
      digits_due.push_back(res);
      return;
    end
    while (quot != 0 && cnt < StackDepth) begin
      stack[cnt] = DigitW'(quot % base);
      quot       = quot / base;
      cnt++;
    end
    for (int i = cnt; i > 0; i--) begin
      res = '{digit: stack[i-1], last_digit: (i == 1), empty_res: 1'b0};
      digits_due.push_back(res);
    end
  endfunction

  function automatic int next_gap();
    int unsigned r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  function automatic logic [ValueW-1:0] pick_value();
    longint unsigned p;
    int unsigned     base;
    int unsigned     k;
    base = eff_radix(radix_now);
    case ($urandom_range(0, 9))
      0: return '0;
      1: return ValueW'($urandom_range(0, 300));
      2, 3, 4: return ValueW'($urandom) >> $urandom_range(0, ValueW - 1);
      5: begin
        // powers of the radix and one below them: digit count boundaries
        p = 1;
        k = $urandom_range(1, ValueW);
        repeat (k) if (p * base <= ValueMax) p = p * base;
        return ValueW'(p - $urandom_range(0, 1));
      end
      default: return ValueW'($urandom);
    endcase
  endfunction

  // waits until the core has drained before writing the radix
  task automatic load_radix(input logic [RadixW-1:0] r);
    in_valid_i <= 1'b0;
    while (digits_due.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_radix_i <= r;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    radix_now = r;
    n_writes++;
  endtask

  task automatic send_value(input logic [ValueW-1:0] v, input bit typed,
                            input digit_res_t typed_res);
    int gap;
    gap = next_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    value_i    <= v;
    do @(posedge clk_i); while (in_stall_o);
    if (typed) digits_due.push_back(typed_res);
    else predict_digits(v);
    n_values++;
  endtask

  always @(posedge clk_i) begin : mon
    digit_res_t got;
    digit_res_t want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        got = '{digit: digit_o, last_digit: last_digit_o, empty_res: empty_res_o};
        n_digits++;
        if (digits_due.size() == 0) begin
          n_bad++;
          if (n_bad <= ShowMax)
            $display("%t: unexpected transfer digit %0d last %0b empty %0b", $realtime,
                     got.digit, got.last_digit, got.empty_res);
        end else begin
          want = digits_due.pop_front();
          if (got !== want) begin
            n_bad++;
            if (n_bad <= ShowMax)
              $display("%t: digit %0d/%0d last %0b/%0b empty %0b/%0b (exp/got)",
                       $realtime, want.digit, got.digit, want.last_digit,
                       got.last_digit, want.empty_res, got.empty_res);
          end
        end
      end
      if ($urandom_range(0, 199) == 0) calm = !calm;
      if (stall_left != 0) begin
        out_stall_i <= 1'b1;
        stall_left--;
      end else begin
        out_stall_i <= 1'b0;
        stall_left = next_gap();
      end
    end
  end

  initial begin : stim
    dir_row_t          dir_rows [24];
    logic [RadixW-1:0] phase_radix [14];
    dir_row_t          row;
    digit_res_t        typed_res;
    // set_radix, radix, value, typed, exp digit, exp empty
    dir_rows = '{
      '{1'b0, 9'd0,   31'd0,          1'b1, 8'd0,   1'b1},  // zero at reset radix
      '{1'b0, 9'd0,   31'd9,          1'b1, 8'd9,   1'b0},  // reset radix is ten
      '{1'b0, 9'd0,   31'd10,         1'b0, 8'd0,   1'b0},
      '{1'b0, 9'd0,   31'h7FFF_FFFF,  1'b0, 8'd0,   1'b0},
      '{1'b1, 9'd2,   31'd1,          1'b1, 8'd1,   1'b0},
      '{1'b0, 9'd0,   31'h7FFF_FFFF,  1'b0, 8'd0,   1'b0},  // 31 digits, deepest stack
      '{1'b0, 9'd0,   31'h4000_0000,  1'b0, 8'd0,   1'b0},
      '{1'b1, 9'd0,   31'd1,          1'b1, 8'd1,   1'b0},  // radix 0 acts as 2
      '{1'b0, 9'd0,   31'd2,          1'b0, 8'd0,   1'b0},
      '{1'b1, 9'd1,   31'd3,          1'b0, 8'd0,   1'b0},  // radix 1 acts as 2
      '{1'b1, 9'd256, 31'd255,        1'b1, 8'd255, 1'b0},
      '{1'b0, 9'd0,   31'd256,        1'b0, 8'd0,   1'b0},
      '{1'b0, 9'd0,   31'h7FFF_FFFF,  1'b0, 8'd0,   1'b0},
      '{1'b1, 9'd511, 31'd255,        1'b1, 8'd255, 1'b0},  // saturates to 256
      '{1'b0, 9'd0,   31'd65535,      1'b0, 8'd0,   1'b0},
      '{1'b1, 9'd257, 31'd0,          1'b1, 8'd0,   1'b1},
      '{1'b0, 9'd0,   31'h5555_5555,  1'b0, 8'd0,   1'b0},
      '{1'b1, 9'd16,  31'd15,         1'b1, 8'd15,  1'b0},
      '{1'b0, 9'd0,   31'h2AAA_AAAA,  1'b0, 8'd0,   1'b0},
      '{1'b1, 9'd3,   31'h7FFF_FFFF,  1'b0, 8'd0,   1'b0},
      '{1'b1, 9'd255, 31'd254,        1'b1, 8'd254, 1'b0},
      '{1'b0, 9'd0,   31'd255,        1'b0, 8'd0,   1'b0},
      '{1'b1, 9'h155, 31'h7FFF_FFFF,  1'b0, 8'd0,   1'b0},
      '{1'b1, 9'd10,  31'd1000000000, 1'b0, 8'd0,   1'b0}
    };
    phase_radix = '{9'd2, 9'd256, 9'd0, 9'd10, 9'd1, 9'd511, 9'd16, 9'd3,
                    9'd0, 9'd0, 9'd7, 9'd255, 9'd100, 9'd37};
    phase_radix[8] = RadixW'($urandom_range(2, 256));
    phase_radix[9] = RadixW'($urandom_range(0, 511));

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) begin
      row = dir_rows[i];
      if (row.set_radix) load_radix(row.radix);
      typed_res = '{digit: row.exp_digit, last_digit: 1'b1, empty_res: row.exp_empty};
      send_value(row.value, row.typed, typed_res);
    end

    foreach (phase_radix[p]) begin
      load_radix(phase_radix[p]);
      repeat (24) send_value(pick_value(), 1'b0, typed_res);
    end

    in_valid_i <= 1'b0;
    while (digits_due.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);

    $display("Converted %0d values under %0d radix writes; %0d digit transfers checked",
             n_values, n_writes, n_digits);
    if (n_bad > ShowMax) $display("%0d mismatches in total", n_bad);
    if (n_bad == 0 && digits_due.size() == 0) begin
      $display("PASS integer_to_radix_digits_core");
    end else begin
      $display("FAIL integer_to_radix_digits_core");
    end
    $finish;
  end

  // radix 2 at full width with long stalls stays well under this
  initial begin : watchdog
    #50_000_000;
    $display("FAIL integer_to_radix_digits_core");
    $finish;
  end

endmodule

// ----- sim.f -----
hw/rtl/ird_pkg.sv
hw/rtl/integer_to_radix_digits_core.sv
hw/rtl/ird_checker.sv
dv/tb.sv
